### sv/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// shared types, constants and helpers of the start code segmenter
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int POS_WIDTH = 32;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [2:0] MIN_ZEROS = 3'd2;
    localparam logic [2:0] ZERO_SAT  = 3'd4;
    localparam logic [2:0] MAX_BACK  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ZERO = 3'b010,
        ST_ONE  = 3'b100
    } t_scan_state;

    typedef logic [POS_WIDTH-1:0] t_pos;

    // item passed from the scanner to the segment builder
    typedef struct packed {
        logic found;
        logic last;
        t_pos offs;
        t_pos end_pos;
    } t_seg_cmd;

    function automatic logic [31:0] to_out32(input t_pos v);
        logic [POS_WIDTH+31:0] t;
        begin
            t = {32'd0, v};
            return t[31:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/scs_front.sv
// ----------------------------------------------------------------------------
// scs_front
// byte scanner: tracks zero runs and position, posts start code and end items
// ----------------------------------------------------------------------------
`default_nettype none

module scs_front
    import scs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_seg_cmd        o_cmd
);

    t_scan_state r_state, n_state;
    t_pos        r_pos, n_pos;
    logic [2:0]  r_zero_run, n_zero_run;
    logic        w_found;
    logic        w_accept;
    logic [2:0]  w_back;
    t_pos        w_pos_inc;

    assign o_ready   = !i_q_full;
    assign w_accept  = i_valid && !i_q_full;
    assign w_pos_inc = r_pos + t_pos'(1);
    assign w_back    = (r_zero_run > 3'd3) ? MAX_BACK : r_zero_run + 3'd1;

    always_comb begin
        n_state    = r_state;
        n_zero_run = r_zero_run;
        n_pos      = r_pos;
        w_found    = 1'b0;
        case (r_state)
            ST_ZERO: begin
                if (i_data_byte == BYTE_ZERO) begin
                    if (r_zero_run < ZERO_SAT) begin
                        n_zero_run = r_zero_run + 3'd1;
                    end
                end else if (i_data_byte == BYTE_ONE) begin
                    n_state = ST_ONE;
                end else begin
                    n_zero_run = 3'd0;
                    n_state    = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (r_zero_run >= MIN_ZEROS) begin
                    w_found = 1'b1;
                end
                n_zero_run = 3'd0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                if (i_data_byte == BYTE_ZERO) begin
                    n_state    = ST_ZERO;
                    n_zero_run = 3'd1;
                end
            end
        endcase
        n_pos = w_pos_inc;
        if (i_last) begin
            n_state    = ST_IDLE;
            n_zero_run = 3'd0;
            n_pos      = '0;
        end
    end

    assign o_push          = w_accept && (w_found || i_last);
    assign o_cmd.found     = w_found;
    assign o_cmd.last      = i_last;
    assign o_cmd.offs      = r_pos - {{(POS_WIDTH-3){1'b0}}, w_back};
    assign o_cmd.end_pos   = w_pos_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_zero_run <= 3'd0;
            r_pos      <= '0;
        end else if (w_accept) begin
            r_state    <= n_state;
            r_zero_run <= n_zero_run;
            r_pos      <= n_pos;
        end
    end

endmodule

`default_nettype wire

### sv/scs_queue.sv
// ----------------------------------------------------------------------------
// scs_queue
// short first-in first-out queue between scanner and segment builder
// ----------------------------------------------------------------------------
`default_nettype none

module scs_queue
    import scs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_seg_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output t_seg_cmd      o_cmd,
    input  wire logic     i_pop
);

    t_seg_cmd            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_do_pop;

    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/scs_back.sv
// ----------------------------------------------------------------------------
// scs_back
// segment builder: keeps the open segment and emits offset and length items
// ----------------------------------------------------------------------------
`default_nettype none

module scs_back
    import scs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_seg_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_seg_offset,
    output logic [31:0]      o_seg_length,
    output logic             o_final
);

    logic        r_valid;
    logic [31:0] r_offset, r_length;
    logic        r_final;
    t_pos        r_prev;
    logic        r_have;
    logic        r_phase;

    logic        w_load;
    logic        w_emit_a;
    t_pos        w_eff_prev;

    assign w_load     = i_q_valid && (!r_valid || i_ready);
    assign w_emit_a   = i_cmd.found && r_have && !r_phase;
    assign w_eff_prev = (i_cmd.found && !r_phase) ? i_cmd.offs : r_prev;
    assign o_pop      = w_load && !(w_emit_a && i_cmd.last);

    assign o_valid      = r_valid;
    assign o_seg_offset = r_offset;
    assign o_seg_length = r_length;
    assign o_final      = r_final;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_emit_a) begin
                r_offset <= to_out32(r_prev);
                r_length <= to_out32(i_cmd.offs - r_prev);
                r_final  <= 1'b0;
            end else begin
                r_offset <= to_out32(w_eff_prev);
                r_length <= to_out32(i_cmd.end_pos - w_eff_prev);
                r_final  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_load) begin
                if (w_emit_a) begin
                    r_valid <= 1'b1;
                    r_prev  <= i_cmd.offs;
                    r_have  <= 1'b1;
                    r_phase <= i_cmd.last;
                end else if (i_cmd.last) begin
                    r_valid <= 1'b1;
                    r_prev  <= '0;
                    r_have  <= 1'b0;
                    r_phase <= 1'b0;
                end else begin
                    r_prev  <= i_cmd.offs;
                    r_have  <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/start_code_segmenter.sv
// ----------------------------------------------------------------------------
// start_code_segmenter
// splits a byte stream at start codes into offset and length segments
// ----------------------------------------------------------------------------
// channel   dir   handshake                 tdata / tuser / tlast
// s_axis    in    i_s_axis_tvalid/tready    tdata[7:0] data_byte, tlast end_of_stream
// m_axis    out   o_m_axis_tvalid/tready    tdata[31:0] seg_offset, [63:32] seg_length,
//                                           tlast final_segment
//
// one byte item per cycle while the queue is not full; the scanner posts start code
// and end items into a four-entry queue, the builder drains one result per cycle from
// it while its output register is free; a start code with a final byte yields two
// results if a segment is open; results are held in the queue and output register
// synchronous active-low reset clears scanner, queue and open segment
// ----------------------------------------------------------------------------
`default_nettype none

module start_code_segmenter
    import scs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // seg_offset, seg_length
    output logic             o_m_axis_tlast
);

    logic     w_q_full;
    logic     w_push;
    t_seg_cmd w_push_cmd;
    logic     w_q_valid;
    t_seg_cmd w_head_cmd;
    logic     w_pop;
    logic [31:0] w_offset, w_length;

    scs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data_byte (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    scs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_pop)
    );

    scs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_cmd        (w_head_cmd),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_seg_offset (w_offset),
        .o_seg_length (w_length),
        .o_final      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_length, w_offset};

endmodule

`default_nettype wire
